// ----- src/bdg_pkg.sv -----
// ============================================================================
// bdg_pkg
// Shared types and constants for the box-drawing glyph pixel generator:
// payload structs, register indexes, code range and segment selection masks.
// ============================================================================
package bdg_pkg;

    // Field widths of the payload and configuration registers
    localparam int CODE_W   = 8;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 5;
    localparam int CFG_W_W  = 6;
    localparam int CFG_H_W  = 7;
    localparam int CFG_DATA_W = 7;

    // Parameter defaults
    localparam int DEF_MAX_CELL_WIDTH  = 32;
    localparam int DEF_MAX_CELL_HEIGHT = 64;

    // Register reset values and the smallest usable cell side
    localparam logic [CFG_W_W-1:0] CELL_WIDTH_RESET  = 6'd8;
    localparam logic [CFG_H_W-1:0] CELL_HEIGHT_RESET = 7'd16;
    localparam int MIN_CELL_SIDE = 3;

    // Handled code range and the block glyph codes
    localparam logic [CODE_W-1:0] CODE_FIRST       = 8'd179;
    localparam logic [CODE_W-1:0] CODE_END         = 8'd224;
    localparam logic [CODE_W-1:0] CODE_FULL_BLOCK  = 8'd219;
    localparam logic [CODE_W-1:0] CODE_LOWER_BLOCK = 8'd220;
    localparam logic [CODE_W-1:0] CODE_LEFT_BLOCK  = 8'd221;
    localparam logic [CODE_W-1:0] CODE_RIGHT_BLOCK = 8'd222;
    localparam logic [CODE_W-1:0] CODE_UPPER_BLOCK = 8'd223;

    // Offset of a code into the selection masks
    localparam int CODE_IDX_W = 6;
    localparam int NUM_SEGS   = 20;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_CELL_WIDTH  = 1'b0,
        REG_CELL_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input item
    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic [ROW_W-1:0]  pixel_row;
        logic [COL_W-1:0]  pixel_col;
    } glyph_in_t;

    // Result item
    typedef struct packed {
        logic pixel_on;
        logic code_handled;
    } glyph_out_t;

    // One-hot mask bit for a code in the handled range
    function automatic logic [2**CODE_IDX_W-1:0] code_bit(input int n);
        code_bit = (2**CODE_IDX_W)'(1) << (n - int'(CODE_FIRST));
    endfunction

    // Codes that select each bar segment
    localparam logic [2**CODE_IDX_W-1:0] SEG_CODES [NUM_SEGS] = '{
        // full-height bar on the left column
        code_bit(179) | code_bit(180) | code_bit(181) | code_bit(182) | code_bit(185) |
        code_bit(186) | code_bit(195) | code_bit(197) | code_bit(198) | code_bit(199) |
        code_bit(204) | code_bit(206) | code_bit(215) | code_bit(216),
        // full-height bar on the right column
        code_bit(182) | code_bit(185) | code_bit(186) | code_bit(199) | code_bit(206) |
        code_bit(215),
        // short left bar on the bottom row
        code_bit(180) | code_bit(181) | code_bit(182) | code_bit(184) | code_bit(185) |
        code_bit(187) | code_bit(190) | code_bit(191) | code_bit(203) | code_bit(206) |
        code_bit(215) | code_bit(217),
        // long left bar on the bottom row
        code_bit(183) | code_bit(188) | code_bit(189) | code_bit(208) | code_bit(210),
        // short left bar on the top row
        code_bit(181) | code_bit(184) | code_bit(185) | code_bit(188) | code_bit(190) |
        code_bit(202) | code_bit(206),
        // long left bar on the top row
        code_bit(187),
        // short right bar on the bottom row
        code_bit(201) | code_bit(203) | code_bit(204) | code_bit(206),
        // long right bar on the bottom row
        code_bit(192) | code_bit(195) | code_bit(198) | code_bit(218) | code_bit(200) |
        code_bit(211) | code_bit(212) | code_bit(213) | code_bit(214),
        // short right bar on the top row
        code_bit(200) | code_bit(202) | code_bit(204) | code_bit(206),
        // long right bar on the top row
        code_bit(198) | code_bit(201) | code_bit(212) | code_bit(213),
        // full bar on the bottom row
        code_bit(193) | code_bit(194) | code_bit(196) | code_bit(197) | code_bit(202) |
        code_bit(205) | code_bit(207) | code_bit(209) | code_bit(215) | code_bit(216),
        // full bar on the top row
        code_bit(203) | code_bit(205) | code_bit(207) | code_bit(209) | code_bit(216),
        // long upper bar on the left column
        code_bit(189) | code_bit(190) | code_bit(192) | code_bit(193) | code_bit(200) |
        code_bit(208) | code_bit(211) | code_bit(212) | code_bit(217),
        // short upper bar on the left column
        code_bit(188) | code_bit(202) | code_bit(206) | code_bit(207),
        // long upper bar on the right column
        code_bit(188) | code_bit(189) | code_bit(208) | code_bit(211),
        // short upper bar on the right column
        code_bit(200) | code_bit(202) | code_bit(204) | code_bit(206),
        // long lower bar on the left column
        code_bit(184) | code_bit(201) | code_bit(213),
        // short lower bar on the left column
        code_bit(183) | code_bit(187) | code_bit(191) | code_bit(194) | code_bit(203) |
        code_bit(206) | code_bit(209) | code_bit(210) | code_bit(214) | code_bit(218),
        // long lower bar on the right column
        code_bit(187),
        // short lower bar on the right column
        code_bit(201) | code_bit(203) | code_bit(183) | code_bit(204) | code_bit(206) |
        code_bit(210) | code_bit(214)
    };

endpackage

// ----- src/box_drawing_glyph_pixel_generator.sv -----
// ============================================================================
// box_drawing_glyph_pixel_generator
// Character generator for box-drawing and block codes: one lit/dark answer
// per pixel position, with the cell size set through two config registers.
// ============================================================================
// Pipeline: an accepted item enters the input register, then the result
//   register, which drives out_valid and out_data.
// Throughput: one item per cycle while not stalled; each stage advances
//   when the next is empty or taken, so a stall only holds full stages.
// Reset: pipeline emptied, cell_width = 8 and cell_height = 16.
module box_drawing_glyph_pixel_generator #(
    parameter int MAX_CELL_WIDTH  = bdg_pkg::DEF_MAX_CELL_WIDTH,
    parameter int MAX_CELL_HEIGHT = bdg_pkg::DEF_MAX_CELL_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bdg_pkg::glyph_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bdg_pkg::glyph_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  bdg_pkg::cfg_reg_t              cfg_index,
    input  logic [bdg_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [bdg_pkg::CFG_W_W-1:0] cell_width_reg;
    logic [bdg_pkg::CFG_H_W-1:0] cell_height_reg;
    bdg_pkg::glyph_in_t  item_reg;
    logic                item_valid_reg;
    bdg_pkg::glyph_out_t result_reg;
    logic                result_valid_reg;
    bdg_pkg::glyph_out_t result_next;
    logic                out_free, item_free;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= bdg_pkg::CELL_WIDTH_RESET;
            cell_height_reg <= bdg_pkg::CELL_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bdg_pkg::REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[bdg_pkg::CFG_W_W-1:0];
                bdg_pkg::REG_CELL_HEIGHT: cell_height_reg <= cfg_data[bdg_pkg::CFG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage readiness: free when empty or when its contents leave this cycle
    assign out_free  = !result_valid_reg || !out_stall;
    assign item_free = !item_valid_reg || out_free;
    assign in_stall  = !item_free;

    // Advance the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_free)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_free && in_valid)
            item_reg <= in_data;
    end

    // Decode the pixel
    bdg_glyph #(
        .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
    ) u_glyph (
        .cell_width  (cell_width_reg),
        .cell_height (cell_height_reg),
        .item        (item_reg),
        .result      (result_next)
    );

    // Advance the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_free)
            result_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && item_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid = result_valid_reg;
    assign out_data  = result_reg;

endmodule

// ----- src/bdg_glyph.sv -----
// ============================================================================
// bdg_glyph
// Pixel decode for one item: derives the bar columns and rows from the cell
// size and ORs the block and bar rectangles that the code selects.
// ============================================================================
module bdg_glyph #(
    parameter int MAX_CELL_WIDTH  = bdg_pkg::DEF_MAX_CELL_WIDTH,
    parameter int MAX_CELL_HEIGHT = bdg_pkg::DEF_MAX_CELL_HEIGHT
) (
    input  logic [bdg_pkg::CFG_W_W-1:0] cell_width,
    input  logic [bdg_pkg::CFG_H_W-1:0] cell_height,
    input  bdg_pkg::glyph_in_t          item,
    output bdg_pkg::glyph_out_t         result
);

    // Widths wide enough for both the register and the parameter limit
    localparam int WLIM_W = $clog2(MAX_CELL_WIDTH + 1);
    localparam int HLIM_W = $clog2(MAX_CELL_HEIGHT + 1);
    localparam int GW = (WLIM_W > bdg_pkg::CFG_W_W) ? WLIM_W : bdg_pkg::CFG_W_W;
    localparam int GH = (HLIM_W > bdg_pkg::CFG_H_W) ? HLIM_W : bdg_pkg::CFG_H_W;

    logic [GW-1:0] w_raw, w_eff, col, lx, rx;
    logic [GH-1:0] h_raw, h_eff, row, ty, by;
    logic [bdg_pkg::CODE_W-1:0]     code_off;
    logic [bdg_pkg::CODE_IDX_W-1:0] code_idx;
    logic handled, in_cell, block_on;
    logic c_lx, c_rx, c_le_lx, c_le_rx, c_ge_lx, c_ge_rx;
    logic r_ty, r_by, r_le_ty, r_le_by, r_ge_ty, r_ge_by;
    logic [bdg_pkg::NUM_SEGS-1:0] seg_hit, seg_sel;

    // Clamp the cell size to the supported range
    always_comb
    begin
        w_raw = GW'(cell_width);
        h_raw = GH'(cell_height);
        if (w_raw < GW'(bdg_pkg::MIN_CELL_SIDE))
            w_eff = GW'(bdg_pkg::MIN_CELL_SIDE);
        else if (w_raw > GW'(MAX_CELL_WIDTH))
            w_eff = GW'(MAX_CELL_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < GH'(bdg_pkg::MIN_CELL_SIDE))
            h_eff = GH'(bdg_pkg::MIN_CELL_SIDE);
        else if (h_raw > GH'(MAX_CELL_HEIGHT))
            h_eff = GH'(MAX_CELL_HEIGHT);
        else
            h_eff = h_raw;
    end

    // Center columns and rows: (n-1)/2 covers both odd and even sizes
    assign lx = (w_eff - GW'(1)) >> 1;
    assign rx = lx + GW'(2);
    assign ty = (h_eff - GH'(1)) >> 1;
    assign by = ty + GH'(2);

    assign col = GW'(item.pixel_col);
    assign row = GH'(item.pixel_row);

    assign handled  = (item.char_code >= bdg_pkg::CODE_FIRST) &&
                      (item.char_code <  bdg_pkg::CODE_END);
    assign in_cell  = (row < h_eff) && (col < w_eff);
    assign code_off = item.char_code - bdg_pkg::CODE_FIRST;
    assign code_idx = code_off[bdg_pkg::CODE_IDX_W-1:0];

    // Position compares shared by all rectangles
    assign c_lx    = (col == lx);
    assign c_rx    = (col == rx);
    assign c_le_lx = (col <= lx);
    assign c_le_rx = (col <= rx);
    assign c_ge_lx = (col >= lx);
    assign c_ge_rx = (col >= rx);
    assign r_ty    = (row == ty);
    assign r_by    = (row == by);
    assign r_le_ty = (row <= ty);
    assign r_le_by = (row <= by);
    assign r_ge_ty = (row >= ty);
    assign r_ge_by = (row >= by);

    // Bar segments; the in-cell test clips them at the output
    assign seg_hit[0]  = c_lx;
    assign seg_hit[1]  = c_rx;
    assign seg_hit[2]  = r_by && c_le_lx;
    assign seg_hit[3]  = r_by && c_le_rx;
    assign seg_hit[4]  = r_ty && c_le_lx;
    assign seg_hit[5]  = r_ty && c_le_rx;
    assign seg_hit[6]  = r_by && c_ge_rx;
    assign seg_hit[7]  = r_by && c_ge_lx;
    assign seg_hit[8]  = r_ty && c_ge_rx;
    assign seg_hit[9]  = r_ty && c_ge_lx;
    assign seg_hit[10] = r_by;
    assign seg_hit[11] = r_ty;
    assign seg_hit[12] = c_lx && r_le_by;
    assign seg_hit[13] = c_lx && r_le_ty;
    assign seg_hit[14] = c_rx && r_le_by;
    assign seg_hit[15] = c_rx && r_le_ty;
    assign seg_hit[16] = c_lx && r_ge_ty;
    assign seg_hit[17] = c_lx && r_ge_by;
    assign seg_hit[18] = c_rx && r_ge_ty;
    assign seg_hit[19] = c_rx && r_ge_by;

    // Look up which segments the code selects
    always_comb
    begin
        for (int s = 0; s < bdg_pkg::NUM_SEGS; s++)
        begin
            seg_sel[s] = bdg_pkg::SEG_CODES[s][code_idx];
        end
    end

    // Half and full blocks
    always_comb
    begin
        case (item.char_code)
            bdg_pkg::CODE_FULL_BLOCK:  block_on = 1'b1;
            bdg_pkg::CODE_UPPER_BLOCK: block_on = !r_ge_by;
            bdg_pkg::CODE_LOWER_BLOCK: block_on = r_ge_by;
            bdg_pkg::CODE_LEFT_BLOCK:  block_on = !c_ge_rx;
            bdg_pkg::CODE_RIGHT_BLOCK: block_on = c_ge_rx;
            default:                   block_on = 1'b0;
        endcase
    end

    assign result.pixel_on     = handled && in_cell && (block_on || |(seg_sel & seg_hit));
    assign result.code_handled = handled;

endmodule

// ----- tb/tb_box_drawing_glyph_pixel_generator.sv -----
// ============================================================================
// Box-drawing glyph pixel generator testbench
// Sends pixel lookups through the valid/stall input channel, predicts each
// pixel's lit state and the handled flag from a local glyph model, and checks
// every result in order. The cell size is swept through normal, minimum,
// maximum and out-of-range values; random gaps and stalls skip quiet phases.
// ============================================================================
module tb_box_drawing_glyph_pixel_generator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 65;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    bdg_pkg::glyph_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bdg_pkg::glyph_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    bdg_pkg::cfg_reg_t cfg_index = bdg_pkg::REG_CELL_WIDTH;
    logic [bdg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copies of the cell size registers
    logic [bdg_pkg::CFG_W_W-1:0] width_reg = bdg_pkg::CELL_WIDTH_RESET;
    logic [bdg_pkg::CFG_H_W-1:0] height_reg = bdg_pkg::CELL_HEIGHT_RESET;

    bdg_pkg::glyph_in_t pixel_queue[$];
    bdg_pkg::glyph_out_t pixel_expect_q[$];
    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int mismatches = 0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    logic quiet = 1'b0;
    int in_gap = 0;
    int stall_left = 0;

    box_drawing_glyph_pixel_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Saturate a register value to the usable cell side range
    function automatic int eff_side(input int v, input int top);
        if (v < bdg_pkg::MIN_CELL_SIDE)
            return bdg_pkg::MIN_CELL_SIDE;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic bit in_box(input int r, input int c, input int x0, input int y0,
                                  input int nx, input int ny);
        return c >= x0 && c < x0 + nx && r >= y0 && r < y0 + ny;
    endfunction

    // Lit state and handled flag for one pixel under the current cell size
    function automatic bdg_pkg::glyph_out_t glyph_pixel(input bdg_pkg::glyph_in_t it);
        int w;
        int h;
        int lx;
        int rx;
        int ty;
        int by;
        int r;
        int c;
        int code;
        logic lit;
        bdg_pkg::glyph_out_t res;
        w = eff_side(int'(width_reg), bdg_pkg::DEF_MAX_CELL_WIDTH);
        h = eff_side(int'(height_reg), bdg_pkg::DEF_MAX_CELL_HEIGHT);
        lx = (w % 2 == 0) ? w / 2 - 1 : w / 2;
        rx = lx + 2;
        ty = (h % 2 == 0) ? h / 2 - 1 : h / 2;
        by = ty + 2;
        r = int'(it.pixel_row);
        c = int'(it.pixel_col);
        code = int'(it.char_code);
        lit = 1'b0;
        res.code_handled = (it.char_code >= bdg_pkg::CODE_FIRST) &&
                           (it.char_code < bdg_pkg::CODE_END);
        if (res.code_handled && r < h && c < w)
        begin
            // Solid blocks
            case (it.char_code)
                bdg_pkg::CODE_FULL_BLOCK:  lit = 1'b1;
                bdg_pkg::CODE_UPPER_BLOCK: lit = in_box(r, c, 0, 0, w, by);
                bdg_pkg::CODE_LOWER_BLOCK: lit = in_box(r, c, 0, by, w, h - by);
                bdg_pkg::CODE_LEFT_BLOCK:  lit = in_box(r, c, 0, 0, rx, h);
                bdg_pkg::CODE_RIGHT_BLOCK: lit = in_box(r, c, rx, 0, w - rx, h);
                default: ;
            endcase
            // Full-height bars
            case (code)
                179, 180, 181, 182, 185, 186, 195, 197, 198, 199, 204, 206, 215, 216:
                    lit |= in_box(r, c, lx, 0, 1, h);
                default: ;
            endcase
            case (code)
                182, 185, 186, 199, 206, 215: lit |= in_box(r, c, rx, 0, 1, h);
                default: ;
            endcase
            // Horizontal bars reaching the left edge
            case (code)
                180, 181, 182, 184, 185, 187, 190, 191, 203, 206, 215, 217:
                    lit |= in_box(r, c, 0, by, lx + 1, 1);
                default: ;
            endcase
            case (code)
                183, 188, 189, 208, 210: lit |= in_box(r, c, 0, by, rx + 1, 1);
                default: ;
            endcase
            case (code)
                181, 184, 185, 188, 190, 202, 206: lit |= in_box(r, c, 0, ty, lx + 1, 1);
                default: ;
            endcase
            case (code)
                187: lit |= in_box(r, c, 0, ty, rx + 1, 1);
                default: ;
            endcase
            // Horizontal bars reaching the right edge
            case (code)
                201, 203, 204, 206: lit |= in_box(r, c, rx, by, w - rx, 1);
                default: ;
            endcase
            case (code)
                192, 195, 198, 200, 211, 212, 213, 214, 218:
                    lit |= in_box(r, c, lx, by, w - lx, 1);
                default: ;
            endcase
            case (code)
                200, 202, 204, 206: lit |= in_box(r, c, rx, ty, w - rx, 1);
                default: ;
            endcase
            case (code)
                198, 201, 212, 213: lit |= in_box(r, c, lx, ty, w - lx, 1);
                default: ;
            endcase
            // Full-width bars
            case (code)
                193, 194, 196, 197, 202, 205, 207, 209, 215, 216:
                    lit |= in_box(r, c, 0, by, w, 1);
                default: ;
            endcase
            case (code)
                203, 205, 207, 209, 216: lit |= in_box(r, c, 0, ty, w, 1);
                default: ;
            endcase
            // Bars from the top edge down to a center row
            case (code)
                189, 190, 192, 193, 200, 208, 211, 212, 217:
                    lit |= in_box(r, c, lx, 0, 1, by + 1);
                default: ;
            endcase
            case (code)
                188, 202, 206, 207: lit |= in_box(r, c, lx, 0, 1, ty + 1);
                default: ;
            endcase
            case (code)
                188, 189, 208, 211: lit |= in_box(r, c, rx, 0, 1, by + 1);
                default: ;
            endcase
            case (code)
                200, 202, 204, 206: lit |= in_box(r, c, rx, 0, 1, ty + 1);
                default: ;
            endcase
            // Bars from a center row down to the bottom edge
            case (code)
                184, 201, 213: lit |= in_box(r, c, lx, ty, 1, h - ty);
                default: ;
            endcase
            case (code)
                183, 187, 191, 194, 203, 206, 209, 210, 214, 218:
                    lit |= in_box(r, c, lx, by, 1, h - by);
                default: ;
            endcase
            case (code)
                187: lit |= in_box(r, c, rx, ty, 1, h - ty);
                default: ;
            endcase
            case (code)
                183, 201, 203, 204, 206, 210, 214: lit |= in_box(r, c, rx, by, 1, h - by);
                default: ;
            endcase
        end
        res.pixel_on = lit;
        return res;
    endfunction

    // Feed pending items, holding each one until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pixel_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pixel_queue.pop_front();
                in_gap <= quiet ? 0 : $urandom_range(0, 15);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Draw a fresh stall count after each result is taken
    always @(negedge clk)
    begin
        int n;
        n = stall_left;
        if (out_took)
            n = quiet ? 0 : $urandom_range(0, 15);
        if (rst_n && n > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= n - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
    end

    // Check each result against the oldest prediction, then log new items
    always @(posedge clk)
    begin
        bdg_pkg::glyph_out_t want;
        in_took <= rst_n && in_valid && !in_stall;
        out_took <= rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pixel_on=%b code_handled=%b",
                                 out_data.pixel_on, out_data.code_handled);
                end
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (out_data.pixel_on !== want.pixel_on ||
                        out_data.code_handled !== want.code_handled)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: pixel_on exp %b got %b, ",
                                      "code_handled exp %b got %b"},
                                     want.pixel_on, out_data.pixel_on,
                                     want.code_handled, out_data.code_handled);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pixel_expect_q.push_back(glyph_pixel(in_data));
                accepted_cnt++;
            end
        end
    end

    task automatic queue_item(input int code, input int row, input int col);
        bdg_pkg::glyph_in_t it;
        it.char_code = 8'(code);
        it.pixel_row = 6'(row);
        it.pixel_col = 5'(col);
        pixel_queue.push_back(it);
        pushed_cnt++;
    endtask

    // Mostly in-cell lookups of handled codes, biased toward the center bars
    task automatic queue_random(input int count);
        int w;
        int h;
        int row;
        int col;
        w = eff_side(int'(width_reg), bdg_pkg::DEF_MAX_CELL_WIDTH);
        h = eff_side(int'(height_reg), bdg_pkg::DEF_MAX_CELL_HEIGHT);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                queue_item($urandom_range(0, 255), $urandom_range(0, 63),
                           $urandom_range(0, 31));
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    row = $urandom_range((h / 2 >= 2) ? h / 2 - 2 : 0, h / 2 + 2);
                    col = $urandom_range((w / 2 >= 2) ? w / 2 - 2 : 0, w / 2 + 2);
                end
                else
                begin
                    row = $urandom_range(0, (h > 63) ? 63 : h);
                    col = $urandom_range(0, (w > 31) ? 31 : w);
                end
                queue_item($urandom_range(int'(bdg_pkg::CODE_FIRST),
                                          int'(bdg_pkg::CODE_END) - 1), row, col);
            end
        end
    endtask

    // Hold until every item is taken and every result has come back
    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input bdg_pkg::cfg_reg_t idx,
                             input logic [bdg_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == bdg_pkg::REG_CELL_WIDTH)
            width_reg = val[bdg_pkg::CFG_W_W-1:0];
        else
            height_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        int widths [NUM_PHASES];
        int heights [NUM_PHASES];
        widths  = '{3, 32, 0, 63, 4, 2, 33, 5, 0, 0};
        heights = '{3, 64, 1, 127, 4, 65, 2, 9, 0, 0};
        widths[8] = $urandom_range(0, 63);
        heights[8] = $urandom_range(0, 127);
        widths[9] = $urandom_range(3, 32);
        heights[9] = $urandom_range(3, 64);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lookups in the reset-size cell: 8 wide, 16 tall
        queue_item(179, 0, 3);
        queue_item(179, 63, 31);
        queue_item(0, 0, 0);
        queue_item(255, 63, 31);
        queue_item(178, 5, 3);
        queue_item(224, 9, 3);
        queue_item(223, 9, 0);
        queue_item(223, 8, 7);
        queue_item(220, 9, 0);
        queue_item(220, 8, 0);
        queue_item(221, 15, 4);
        queue_item(221, 15, 5);
        queue_item(222, 15, 5);
        queue_item(219, 15, 7);
        queue_item(219, 16, 0);
        queue_item(219, 0, 8);
        queue_item(206, 7, 0);
        queue_item(187, 9, 3);
        queue_item(201, 9, 7);
        queue_item(196, 9, 0);
        queue_item(218, 15, 3);
        wait_idle();

        // Sweep cell sizes, including saturated and clipped ones
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            quiet = (ph % 3 == 2);
            write_reg(bdg_pkg::REG_CELL_WIDTH, {1'($urandom_range(0, 1)), 6'(widths[ph])});
            write_reg(bdg_pkg::REG_CELL_HEIGHT, 7'(heights[ph]));
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pixel_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
